// ===== rtl/core/canf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CAN ID acceptance filter.
// No dependencies; imported by canf_cam and can_id_acceptance_filter.
package canf_pkg;

    // Field widths fixed by the item format
    localparam int CAN_ID_W   = 29;
    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;

    // Defaults for the top-level parameters
    localparam int LIST_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF      = 29;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Filter mode register values
    typedef enum logic [MODE_W-1:0] {
        MODE_ACCEPT_ALL   = 2'd0,
        MODE_INCLUDE_ONLY = 2'd1,
        MODE_EXCLUDE_LIST = 2'd2,
        MODE_REJECT_ALL   = 2'd3
    } t_mode;

    // Update command to one ID list
    typedef struct packed {
        logic add;
        logic remove;
        logic clear;
    } t_cam_cmd;

endpackage

// ===== rtl/core/canf_cam.sv =====
`timescale 1ns / 1ps
// One exact-match ID list: entry storage, valid bits, parallel compare.
// Depends on canf_pkg (t_cam_cmd).
module canf_cam #(
    parameter int LIST_ENTRIES = canf_pkg::LIST_ENTRIES_DEF,
    parameter int ID_BITS      = canf_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ID_BITS-1:0]  i_key,
    input  canf_pkg::t_cam_cmd  i_cmd,
    output logic                o_hit,
    output logic                o_full
);
    import canf_pkg::*;

    logic [ID_BITS-1:0]      r_ids [LIST_ENTRIES];
    logic [LIST_ENTRIES-1:0] r_valid;
    logic [LIST_ENTRIES-1:0] n_valid;
    logic [LIST_ENTRIES-1:0] match;
    logic [LIST_ENTRIES-1:0] free;
    logic [LIST_ENTRIES-1:0] first_free;
    logic                    do_write;

    // Parallel compare against every valid entry
    always_comb begin
        for (int i = 0; i < LIST_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_ids[i] == i_key);
        end
    end

    assign o_hit      = |match;
    assign o_full     = &r_valid;
    assign free       = ~r_valid;
    // lowest free entry as a one-hot vector
    assign first_free = free & (~free + LIST_ENTRIES'(1));
    assign do_write   = i_cmd.add && !o_hit && !o_full;

    // Valid-bit update
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = '0;
        end else if (i_cmd.remove) begin
            n_valid = r_valid & ~match;
        end else if (do_write) begin
            n_valid = r_valid | first_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry storage, no reset: never read without its valid bit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LIST_ENTRIES; i++) begin
            if (do_write && first_free[i]) begin
                r_ids[i] <= i_key;
            end
        end
    end

endmodule

// ===== rtl/core/can_id_acceptance_filter.sv =====
`timescale 1ns / 1ps
// CAN ID acceptance filter with include and exclude exact-match lists.
// Pipeline: input register, then result register. One item per cycle
// unless i_out_stall holds a result; each list update commits as its
// item leaves the input register, so the following item sees it.
// Reset: pipeline empty, all list entries invalid, filter mode 0.
// Depends on canf_pkg and canf_cam.
module can_id_acceptance_filter #(
    parameter int LIST_ENTRIES = canf_pkg::LIST_ENTRIES_DEF,
    parameter int ID_BITS      = canf_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [canf_pkg::MODE_W-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [canf_pkg::OP_W-1:0]     i_op,
    input  logic [canf_pkg::CAN_ID_W-1:0] i_can_id,
    input  logic                          i_list_select,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accept,
    output logic                          o_status
);
    import canf_pkg::*;

    t_mode              r_mode;
    logic               r_in_valid;
    t_op                r_op;
    logic [ID_BITS-1:0] r_key;
    logic               r_sel;
    logic               r_out_valid;
    logic               r_accept;
    logic               r_status;

    logic [ID_BITS-1:0] in_key;
    logic               in_take;
    logic               out_load;
    logic               advance;
    t_cam_cmd           inc_cmd;
    t_cam_cmd           exc_cmd;
    logic               inc_hit;
    logic               inc_full;
    logic               exc_hit;
    logic               exc_full;
    logic               n_accept;
    logic               n_status;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ACCEPT_ALL;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    // Handshake: stage 1 moves on when the result register is empty or not stalled
    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // Key: low ID_BITS of the identifier, zero-extended when wider
    always_comb begin
        in_key = '0;
        for (int b = 0; b < ID_BITS && b < CAN_ID_W; b++) begin
            in_key[b] = i_can_id[b];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= t_op'(i_op);
            r_key <= in_key;
            r_sel <= i_list_select;
        end
    end

    // List commands, issued only as the item leaves stage 1
    always_comb begin
        inc_cmd = '0;
        exc_cmd = '0;
        if (advance) begin
            case (r_op)
                OP_ADD: begin
                    inc_cmd.add = !r_sel;
                    exc_cmd.add = r_sel;
                end
                OP_REMOVE: begin
                    inc_cmd.remove = 1'b1;
                    exc_cmd.remove = 1'b1;
                end
                OP_CLEAR: begin
                    inc_cmd.clear = 1'b1;
                    exc_cmd.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    canf_cam #(
        .LIST_ENTRIES (LIST_ENTRIES),
        .ID_BITS      (ID_BITS)
    ) u_include (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .i_cmd   (inc_cmd),
        .o_hit   (inc_hit),
        .o_full  (inc_full)
    );

    canf_cam #(
        .LIST_ENTRIES (LIST_ENTRIES),
        .ID_BITS      (ID_BITS)
    ) u_exclude (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .i_cmd   (exc_cmd),
        .o_hit   (exc_hit),
        .o_full  (exc_full)
    );

    // Result decision
    always_comb begin
        n_accept = 1'b0;
        n_status = 1'b0;
        case (r_op)
            OP_LOOKUP: begin
                case (r_mode)
                    MODE_ACCEPT_ALL:   n_accept = 1'b1;
                    MODE_INCLUDE_ONLY: n_accept = inc_hit;
                    MODE_EXCLUDE_LIST: n_accept = !exc_hit;
                    MODE_REJECT_ALL:   n_accept = 1'b0;
                    default:           n_accept = 1'b0;
                endcase
            end
            OP_ADD: begin
                // refused only when the ID is absent and the list is full
                n_status = r_sel ? (exc_full && !exc_hit) : (inc_full && !inc_hit);
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_accept <= n_accept;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accept    = r_accept;
    assign o_status    = r_status;

endmodule
